/* sv/khc_pkg.sv */
// khc_pkg: shared types and constants of the keyframe hermite curve block
// no dependencies
`timescale 1ns / 1ps
package khc_pkg;

  localparam int unsigned MaxKeys = 32;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = 6;
  localparam int unsigned KeyW    = 16 + 32 + 32 + 32;

  localparam logic [15:0] OneT  = 16'd32768;
  localparam logic [31:0] OneV  = 32'd65536;
  localparam logic [31:0] HalfV = 32'd32768;

  typedef enum logic [1:0] {
    ActEval   = 2'd0,
    ActAdd    = 2'd1,
    ActRemove = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StDone   = 2'd0,
    StIgnore = 2'd1,
    StFull   = 2'd2,
    StRange  = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] t;
    logic [31:0] v;
    logic [31:0] out_s;
    logic [31:0] in_s;
  } key_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [17:0] time_point;
    logic [31:0] new_value;
    logic [4:0]  key_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] curve_value;
    logic [1:0]  status;
    logic [5:0]  key_total;
  } out_item_t;

  typedef enum logic [4:0] {
    SIdle, SClear, SRdFirst, SRdLast, SChkEnds, SScanRd, SScan,
    SMove, SMoveWr, SInsert, SRdA, SRdB, SDiv, SMul, SOut
  } state_e;

endpackage

/* sv/khc_if.sv */
// khc_if: valid/ready channel carrying one payload
// depends on khc_pkg only through the payload type parameter
`timescale 1ns / 1ps
interface khc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/khc_ram.sv */
// khc_ram: generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
module khc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/keyframe_hermite_curve_top.sv */
// keyframe hermite curve: one transaction in, one result out, sequenced over a key ram
// evaluate: linear segment scan reading one key at a time, a restoring divider and 6 serial
// multiplies through the shared multiplier; add/remove: keys moved one at a time through the
// ram's read and write ports. one transaction at a time.
// reset: asynchronous, clears control; SClear then rewrites the two end anchors.
`timescale 1ns / 1ps
module keyframe_hermite_curve_top import khc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  khc_if.sink   in_ch,
  khc_if.source out_ch
);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW:0]   i_q, i_d;         // scan / move pointer
  logic [IdxW:0]   seg_q, seg_d;     // segment / insert position
  in_item_t        it_q, it_d;
  out_item_t       res_q, res_d;
  logic            ov_q, ov_d;
  logic            dir_q, dir_d;     // 1 move up for insert, 0 move down for remove
  key_t            ka_q, ka_d, kb_q, kb_d;
  logic signed [17:0] t_q, t_d;
  // divider
  logic [5:0]  dc_q, dc_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] w_q, w_d;
  // multiplier sequencing
  logic [2:0]  mc_q, mc_d;
  logic [16:0] u_q, u_d, u2_q, u2_d, u3_q, u3_d;
  logic signed [67:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic        pv_q, pv_d;

  // ram
  logic        we;
  logic [IdxW-1:0] wa, ra;
  key_t        wd, rd;

  khc_ram #(.Width(KeyW), .Depth(MaxKeys)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );

  // shared multiplier operands
  logic signed [34:0] ma;
  logic signed [34:0] mb;
  logic signed [69:0] mp;
  assign mp = ma * mb;

  // hermite basis from registered powers
  logic signed [19:0] h00, h10, h01, h11;
  always_comb begin
    h00 = 20'sd65536 + 20'($signed({3'b0, u3_q})) * 20'sd2
          - 20'($signed({3'b0, u2_q})) * 20'sd3;
    h10 = 20'($signed({3'b0, u3_q})) - 20'($signed({3'b0, u2_q})) * 20'sd2
          + 20'($signed({3'b0, u_q}));
    h01 = 20'($signed({3'b0, u2_q})) * 20'sd3 - 20'($signed({3'b0, u3_q})) * 20'sd2;
    h11 = 20'($signed({3'b0, u3_q})) - 20'($signed({3'b0, u2_q}));
  end

  logic signed [17:0] tclamp;
  logic signed [17:0] rd_t;
  logic signed [17:0] tin;
  assign tin  = $signed(it_q.time_point);
  assign rd_t = $signed({2'b0, rd.t});
  assign tclamp = (tin < 0) ? 18'sd0 : (tin > 18'sd32768) ? 18'sd32768 : tin;

  logic signed [67:0] fin;
  logic signed [67:0] rnd;
  assign fin = acc_q + 68'sd32768;
  assign rnd = fin >>> 16;

  // next state and datapath
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; seg_d = seg_q; it_d = it_q;
    res_d = res_q; ov_d = ov_q; dir_d = dir_q; ka_d = ka_q; kb_d = kb_q; t_d = t_q;
    dc_d = dc_q; rem_d = rem_q; quo_d = quo_q; w_d = w_q; mc_d = mc_q;
    u_d = u_q; u2_d = u2_q; u3_d = u3_q; acc_d = acc_q; prod_d = prod_q; pv_d = 1'b0;
    we = 1'b0; wa = '0; wd = '0; ra = '0; ma = '0; mb = '0;
    if (ov_q && out_ch.ready) ov_d = 1'b0;
    case (state_q)
      SClear: begin
        we = 1'b1;
        wa = i_q[IdxW-1:0];
        wd = (i_q == 0) ? key_t'{16'd0, 32'd0, OneV, 32'd0} : key_t'{OneT, OneV, 32'd0, OneV};
        i_d = i_q + 1'b1;
        if (i_q != 0) state_d = SIdle;
      end
      SIdle: begin
        if (in_ch.valid && !ov_q) begin
          it_d = in_ch.payload;
          res_d = '{curve_value: '0, status: StIgnore, key_total: cnt_q};
          case (action_e'(in_ch.payload.action))
            ActEval, ActAdd: begin
              ra = '0; state_d = SRdFirst;
            end
            ActRemove: begin
              if ({1'b0, in_ch.payload.key_index} >= cnt_q) begin
                res_d.status = StRange; ov_d = 1'b1;
              end else if (in_ch.payload.key_index == 0 ||
                           {1'b0, in_ch.payload.key_index} == cnt_q - 1'b1) begin
                ov_d = 1'b1;
              end else begin
                dir_d = 1'b0; i_d = {1'b0, in_ch.payload.key_index} + 1'b1;
                ra = in_ch.payload.key_index + 1'b1;
                state_d = SMove;
              end
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      SRdFirst: begin
        ka_d = rd;
        ra = IdxW'(cnt_q - 1'b1);
        state_d = SRdLast;
      end
      SRdLast: begin
        kb_d = rd;
        state_d = SChkEnds;
      end
      SChkEnds: begin
        if (it_q.action == ActEval) begin
          t_d = tin;
          if (tin <= $signed({2'b0, ka_q.t})) begin
            res_d.curve_value = ka_q.v; res_d.status = StDone; ov_d = 1'b1; state_d = SIdle;
          end else if (tin >= $signed({2'b0, kb_q.t})) begin
            res_d.curve_value = kb_q.v; res_d.status = StDone; ov_d = 1'b1; state_d = SIdle;
          end else begin
            i_d = {{IdxW{1'b0}}, 1'b1}; ra = IdxW'(1); state_d = SScan;
          end
        end else begin
          t_d = tclamp; i_d = {{IdxW{1'b0}}, 1'b1}; ra = IdxW'(1); state_d = SScan;
        end
      end
      SScanRd: begin
        ra = i_q[IdxW-1:0]; state_d = SScan;
      end
      SScan: begin
        // rd = key i; ka holds key i-1
        if (it_q.action == ActEval) begin
          if (t_q <= rd_t) begin
            kb_d = rd; seg_d = i_q; state_d = SDiv;
            w_d = 17'(rd.t - ka_q.t);
            rem_d = '0; quo_d = {16'(t_q - $signed({2'b0, ka_q.t})), 16'd0};
            dc_d = 6'd32;
          end else begin
            ka_d = rd; i_d = i_q + 1'b1; state_d = SScanRd;
          end
        end else begin
          if (t_q > $signed({2'b0, ka_q.t}) && t_q < rd_t) begin
            if (cnt_q >= CntW'(MaxKeys)) begin
              res_d.status = StFull; ov_d = 1'b1; state_d = SIdle;
            end else begin
              seg_d = i_q; dir_d = 1'b1; i_d = {1'b0, cnt_q[IdxW-1:0]};
              ra = IdxW'(cnt_q - 1'b1); state_d = SMove;
            end
          end else if (i_q + 1'b1 >= {1'b0, cnt_q}) begin
            ov_d = 1'b1; state_d = SIdle;
          end else begin
            ka_d = rd; i_d = i_q + 1'b1; state_d = SScanRd;
          end
        end
      end
      SMove: begin
        // read of source issued last cycle; write it this cycle
        we = 1'b1;
        wd = rd;
        if (dir_q) begin
          wa = i_q[IdxW-1:0];
          if (i_q - 1'b1 == seg_q) begin
            state_d = SInsert;
          end else begin
            i_d = i_q - 1'b1; state_d = SMoveWr;
          end
        end else begin
          wa = IdxW'(i_q - 1'b1);
          if (i_q + 1'b1 >= {1'b0, cnt_q}) begin
            cnt_d = cnt_q - 1'b1; res_d.status = StDone; res_d.key_total = cnt_q - 1'b1;
            ov_d = 1'b1; state_d = SIdle;
          end else begin
            i_d = i_q + 1'b1; state_d = SMoveWr;
          end
        end
      end
      SMoveWr: begin
        ra = dir_q ? IdxW'(i_q - 1'b1) : i_q[IdxW-1:0];
        state_d = SMove;
      end
      SInsert: begin
        we = 1'b1; wa = seg_q[IdxW-1:0];
        wd = '{t: t_q[15:0], v: it_q.new_value, out_s: HalfV, in_s: HalfV};
        cnt_d = cnt_q + 1'b1; res_d.status = StDone; res_d.key_total = cnt_q + 1'b1;
        ov_d = 1'b1; state_d = SIdle;
      end
      SDiv: begin
        // restoring divide, one quotient bit a cycle
        if (dc_q != 0) begin
          logic [32:0] r2;
          r2 = {rem_q[31:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
          if (r2 >= {16'd0, w_q}) begin
            rem_d = r2 - {16'd0, w_q}; quo_d[0] = 1'b1;
          end else begin
            rem_d = r2;
          end
          dc_d = dc_q - 1'b1;
        end else begin
          u_d = quo_q[16:0]; mc_d = '0; acc_d = '0; state_d = SMul;
        end
      end
      SMul: begin
        // one product per cycle through the shared multiplier, registered
        case (mc_q)
          3'd0: begin ma = {18'd0, u_q}; mb = {18'd0, u_q}; end
          3'd1: begin ma = {18'd0, u2_q}; mb = {18'd0, u_q}; end
          3'd2: begin ma = 35'(signed'(ka_q.v)); mb = 35'(h00); end
          3'd3: begin ma = 35'(signed'(ka_q.out_s)); mb = 35'(h10); end
          3'd4: begin ma = 35'(signed'(kb_q.v)); mb = 35'(h01); end
          3'd5: begin ma = 35'(signed'(kb_q.in_s)); mb = 35'(h11); end
          default: ;
        endcase
        case (mc_q)
          3'd0: begin u2_d = 17'(mp >>> 16); mc_d = 3'd1; end
          3'd1: begin u3_d = 17'(mp >>> 16); mc_d = 3'd2; end
          3'd6: state_d = SOut;
          default: begin prod_d = 64'(mp); pv_d = 1'b1; mc_d = mc_q + 1'b1; end
        endcase
        if (pv_q) acc_d = acc_q + 68'(prod_q);
      end
      SOut: begin
        if (pv_q) begin
          acc_d = acc_q + 68'(prod_q);
        end else begin
          res_d.status = StDone;
          res_d.curve_value = (rnd > 68'sd2147483647) ? 32'h7fffffff :
                              (rnd < -68'sd2147483648) ? 32'h80000000 : rnd[31:0];
          ov_d = 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // handshake outputs
  assign in_ch.ready    = (state_q == SIdle) && !ov_q;
  assign out_ch.valid   = ov_q;
  assign out_ch.payload = res_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; cnt_q <= CntW'(2); i_q <= '0; ov_q <= 1'b0; pv_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; i_q <= i_d; ov_q <= ov_d; pv_q <= pv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    seg_q <= seg_d; it_q <= it_d; res_q <= res_d; dir_q <= dir_d; ka_q <= ka_d;
    kb_q <= kb_d; t_q <= t_d; dc_q <= dc_d; rem_q <= rem_d; quo_q <= quo_d; w_q <= w_d;
    mc_q <= mc_d; u_q <= u_d; u2_q <= u2_d; u3_q <= u3_d; acc_q <= acc_d; prod_q <= prod_d;
  end

  // key count stays within table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= CntW'(2) && cnt_q <= CntW'(MaxKeys)) else $error("key count out of range");
  // result register not overwritten while pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ch.ready |=> ov_q && $stable(res_q)) else $error("result lost");
  // count changes only with a completed edit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> $rose(ov_q)) else $error("count changed without result");
  // no input accepted while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> state_q == SIdle) else $error("ready while busy");

endmodule
